FILE: hdl/qpht_pkg.sv
// types and codes shared by the quadratic probe hash table files
package qpht_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_FIND   = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] OUT_OK     = 2'd0;
	localparam logic [1:0] OUT_ABSENT = 2'd1;
	localparam logic [1:0] OUT_FULL   = 2'd2;

	localparam logic [1:0] ST_EMPTY    = 2'd0;
	localparam logic [1:0] ST_OCCUPIED = 2'd1;
	localparam logic [1:0] ST_TOMB     = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] key;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [31:0] value_out;
		logic [9:0]  entry_count;
	} rsp_t;

endpackage

FILE: hdl/quadratic_probe_hash_table.sv
// open-addressing key/value table with quadratic probing over slot memories
// result path: home slot reduction (reciprocal multiply, back-multiply and subtract, correction),
// then a read and an evaluate state per probe, then S_DONE loads the output; unused code skips to S_DONE
// requests: one at a time, the next taken in S_IDLE once the result is offered; a stalled result
// keeps the next result waiting in S_DONE and so holds back the request after it
// reset: a clearing pass marks every slot empty, one slot a cycle, no request taken
// meanwhile; arst_n clears control state, the entry count and the probe limit (to 1021)
module quadratic_probe_hash_table #(
	parameter int TABLE_SLOTS = 1021,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qpht_pkg::req_t      in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output qpht_pkg::rsp_t      out_data,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_wdata
);
	import qpht_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int KW = (KEY_BITS > 32) ? 32 : KEY_BITS;
	localparam int VW = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam logic [AW:0] SLOTS = (AW+1)'(TABLE_SLOTS);
	// reciprocal of the slot count, scaled so the quotient estimate is at most one short
	localparam logic [KW:0] RECIP = (KW+1)'((64'd1 << (KW + AW)) / 64'(TABLE_SLOTS));

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HOME, S_READ, S_EVAL, S_DONE} state_t;

	// slot memories
	logic [1:0]    mem_st  [TABLE_SLOTS];
	logic [KW-1:0] mem_key [TABLE_SLOTS];
	logic [VW-1:0] mem_val [TABLE_SLOTS];

	state_t        state_q;
	logic [10:0]   limit_q;
	logic [9:0]    count_q;
	logic [1:0]    act_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;
	logic [KW-1:0] quot_q;    // estimated key / slots
	logic [AW:0]   rem_q;     // key - quotient * slots, below twice the slot count
	logic [1:0]    phase_q;   // home slot reduction step
	logic [AW-1:0] slot_q;    // current probe slot
	logic [AW:0]   step_q;    // 2i+1 mod slots, added each probe
	logic [10:0]   probes_q;
	logic          have_free_q;
	logic [AW-1:0] free_q;
	logic [1:0]    rd_st;
	logic [KW-1:0] rd_key;
	logic [VW-1:0] rd_val;
	logic          out_valid_q;
	rsp_t          res_q;     // finished result waiting for the output register
	rsp_t          out_q;

	logic [2*KW:0] prod;
	logic [KW-1:0] quot_w;
	logic [KW+AW:0] qn_w;
	logic [KW+AW:0] rem_w;
	logic [AW:0]   nslot;
	logic [AW+1:0] nstep;
	logic [10:0]   lim;

	assign lim = (limit_q == '0) ? 11'd1 : limit_q;
	// home slot: reciprocal multiply, back-multiply and subtract, then one correction
	assign prod   = (2*KW+1)'(key_q) * (2*KW+1)'(RECIP);
	assign quot_w = KW'(prod >> (KW + AW));
	assign qn_w   = (KW+AW+1)'(quot_q) * (KW+AW+1)'(TABLE_SLOTS);
	assign rem_w  = (KW+AW+1)'(key_q) - qn_w;
	assign nslot = {1'b0, slot_q} + step_q;
	assign nstep = {1'b0, step_q} + (AW+2)'(2);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// memory read port, registered
	always_ff @(posedge clk) begin
		rd_st  <= mem_st[slot_q];
		rd_key <= mem_key[slot_q];
		rd_val <= mem_val[slot_q];
	end

	// memory write port: clearing pass or request update
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem_st[slot_q] <= ST_EMPTY;
		end else if (state_q == S_EVAL) begin
			if (rd_st == ST_OCCUPIED && rd_key == key_q) begin
				if (act_q == ACT_INSERT) mem_val[slot_q] <= val_q;
				if (act_q == ACT_DELETE) mem_st[slot_q] <= ST_TOMB;
			end else if ((rd_st == ST_EMPTY || probes_q + 11'd1 == lim)
					&& act_q == ACT_INSERT) begin
				if (have_free_q || rd_st != ST_OCCUPIED) begin
					if (have_free_q) begin
						mem_st[free_q]  <= ST_OCCUPIED;
						mem_key[free_q] <= key_q;
						mem_val[free_q] <= val_q;
					end else begin
						mem_st[slot_q]  <= ST_OCCUPIED;
						mem_key[slot_q] <= key_q;
						mem_val[slot_q] <= val_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			limit_q     <= 11'd1021;
			count_q     <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			// result taken; a waiting one is loaded in S_DONE instead
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if ({1'b0, slot_q} == SLOTS - (AW+1)'(1)) begin
						state_q <= S_IDLE;
						slot_q  <= '0;
					end else begin
						slot_q <= slot_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q    <= in_data.action;
						key_q    <= in_data.key[KW-1:0];
						val_q    <= in_data.value_in[VW-1:0];
						rem_q    <= '0;
						phase_q  <= '0;
						probes_q <= '0;
						step_q   <= (AW+1)'(1);
						have_free_q <= 1'b0;
						if (in_data.action == ACT_NONE) begin
							state_q <= S_DONE;
							res_q   <= '{OUT_ABSENT, 32'd0, count_q};
						end else begin
							state_q <= S_HOME;
						end
					end
				end
				S_HOME: begin
					if (phase_q == 2'd0) quot_q <= quot_w;
					if (phase_q == 2'd1) rem_q <= rem_w[AW:0];
					if (phase_q == 2'd2) begin
						slot_q  <= (rem_q >= SLOTS) ? AW'(rem_q - SLOTS) : AW'(rem_q);
						state_q <= S_READ;
					end
					phase_q <= phase_q + 2'd1;
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_DONE;
					if (rd_st == ST_OCCUPIED && rd_key == key_q) begin
						res_q.outcome     <= OUT_OK;
						res_q.value_out   <= (act_q == ACT_FIND) ? 32'(rd_val) : 32'd0;
						res_q.entry_count <= (act_q == ACT_DELETE && count_q != '0)
							? count_q - 10'd1 : count_q;
						if (act_q == ACT_DELETE && count_q != '0) count_q <= count_q - 10'd1;
					end else if (rd_st == ST_EMPTY || probes_q + 11'd1 == lim) begin
						res_q.value_out <= 32'd0;
						if (act_q == ACT_INSERT) begin
							if (have_free_q || rd_st != ST_OCCUPIED) begin
								res_q.outcome     <= OUT_OK;
								res_q.entry_count <= count_q + 10'd1;
								count_q           <= count_q + 10'd1;
							end else begin
								res_q.outcome     <= OUT_FULL;
								res_q.entry_count <= count_q;
							end
						end else begin
							res_q.outcome     <= (rd_st == ST_EMPTY) ? OUT_ABSENT : OUT_FULL;
							res_q.entry_count <= count_q;
						end
					end else begin
						// next probe
						if (!have_free_q && rd_st != ST_OCCUPIED) begin
							have_free_q <= 1'b1;
							free_q      <= slot_q;
						end
						probes_q <= probes_q + 11'd1;
						slot_q   <= (nslot >= SLOTS) ? AW'(nslot - SLOTS) : AW'(nslot);
						step_q   <= (nstep >= {1'b0, SLOTS}) ? (AW+1)'(nstep - {1'b0, SLOTS})
							: (AW+1)'(nstep);
						state_q  <= S_READ;
					end
				end
				S_DONE: begin
					// load the output register once it is free or being taken
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/qpht_checker.sv
// port-level checks for the quadratic probe hash table
module qpht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input qpht_pkg::rsp_t out_data
);
	import qpht_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// outcome code is never the unused one
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.outcome <= OUT_FULL)
		else $error("bad outcome code");

	// value only on success
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.outcome != OUT_OK |-> out_data.value_out == 32'd0)
		else $error("value on failure");

	// a transfer in stalls the input the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled while busy");

endmodule

bind quadratic_probe_hash_table qpht_checker u_chk (.*, .out_data(out_data));

FILE: tb/tb.sv
// self-checking testbench for the quadratic probe hash table
module tb;
	import qpht_pkg::*;

	localparam int SLOTS = 1021;

	// predicted table contents and the expected result queue
	class table_scoreboard;
		logic [1:0]  st [SLOTS];
		logic [31:0] keys [SLOTS];
		logic [31:0] vals [SLOTS];
		int unsigned occupied;
		logic [10:0] limit;
		rsp_t        pending [$];
		int          errors;

		function void clear();
			foreach (st[i]) st[i] = ST_EMPTY;
			occupied = 0;
			limit = 11'd1021;
			pending.delete();
			errors = 0;
		endfunction

		// walk the probe sequence and apply the request, queue the result
		function void note_request(req_t r);
			int unsigned lim, home, s, i, hit_slot, free_slot;
			bit hit, ended, have_free;
			rsp_t p;
			lim = (limit == 0) ? 1 : limit;
			home = r.key % SLOTS;
			hit = 0; ended = 0; have_free = 0; hit_slot = 0; free_slot = 0;
			p.outcome = OUT_FULL;
			p.value_out = '0;
			if (r.action == ACT_NONE) begin
				p.outcome = OUT_ABSENT;
				p.entry_count = occupied[9:0];
				pending.push_back(p);
				return;
			end
			for (i = 0; i < lim; i++) begin
				s = (home + (i * i) % SLOTS) % SLOTS;
				if (st[s] == ST_OCCUPIED) begin
					if (keys[s] == r.key) begin
						hit = 1;
						hit_slot = s;
						break;
					end
				end else begin
					if (!have_free) begin
						have_free = 1;
						free_slot = s;
					end
					if (st[s] == ST_EMPTY) begin
						ended = 1;
						break;
					end
				end
			end
			case (r.action)
				ACT_INSERT: begin
					if (hit) begin
						vals[hit_slot] = r.value_in;
						p.outcome = OUT_OK;
					end else if (have_free) begin
						st[free_slot] = ST_OCCUPIED;
						keys[free_slot] = r.key;
						vals[free_slot] = r.value_in;
						occupied++;
						p.outcome = OUT_OK;
					end
				end
				ACT_FIND: begin
					if (hit) begin
						p.value_out = vals[hit_slot];
						p.outcome = OUT_OK;
					end else p.outcome = ended ? OUT_ABSENT : OUT_FULL;
				end
				default: begin
					if (hit) begin
						st[hit_slot] = ST_TOMB;
						if (occupied > 0) occupied--;
						p.outcome = OUT_OK;
					end else p.outcome = ended ? OUT_ABSENT : OUT_FULL;
				end
			endcase
			p.entry_count = occupied[9:0];
			pending.push_back(p);
		endfunction

		task check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report("result with nothing pending");
				return;
			end
			want = pending.pop_front();
			if (got.outcome !== want.outcome)
				report($sformatf("outcome %0d, predicted %0d", got.outcome, want.outcome));
			if (got.value_out !== want.value_out)
				report($sformatf("value_out %h, predicted %h", got.value_out, want.value_out));
			if (got.entry_count !== want.entry_count)
				report($sformatf("entry_count %0d, predicted %0d",
					got.entry_count, want.entry_count));
		endtask

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_valid;
	logic        out_stall;
	rsp_t        out_data;
	logic        cfg_we;
	logic [10:0] cfg_wdata;

	table_scoreboard board;

	// idle and stall percentages for the current phase
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;   // long receiver hold-off, counted down by the receiver
	logic [31:0] used_keys [$]; // keys written so far, to aim later requests

	quadratic_probe_hash_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random stalls, plus the long hold-off when asked
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// one transfer on the request side, with random idle cycles first
	task automatic send(input logic [1:0] act, input logic [31:0] k, input logic [31:0] v);
		req_t r;
		r.action = act;
		r.key = k;
		r.value_in = v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(r);
		if (act == ACT_INSERT) used_keys.push_back(k);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	// only while idle; the limit register takes effect on the next request
	task automatic set_limit(input logic [10:0] lim);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.limit = lim;
	endtask

	// keys that were inserted before half the time, some colliding on one home slot
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50 && used_keys.size() > 0)
			return used_keys[$urandom_range(used_keys.size() - 1)];
		else if (sel < 75)
			return 32'd17 + SLOTS * $urandom_range(40);
		else if (sel < 85)
			return $urandom_range(300);
		return $urandom();
	endfunction

	task automatic random_run(input int n);
		int sel;
		logic [1:0] act;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			act = (sel < 50) ? ACT_INSERT : (sel < 75) ? ACT_FIND :
				(sel < 97) ? ACT_DELETE : ACT_NONE;
			send(act, pick_key(), $urandom());
		end
	endtask

	initial begin
		board = new();
		board.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every action, collisions and the unused code
		send(ACT_FIND, 32'd0, 32'd0);
		send(ACT_DELETE, 32'd0, 32'd0);
		send(ACT_INSERT, 32'd0, 32'hFFFFFFFF);
		send(ACT_INSERT, 32'hFFFFFFFF, 32'h0);
		send(ACT_FIND, 32'hFFFFFFFF, 32'h12345678);
		send(ACT_INSERT, 32'd0, 32'hA5A5A5A5);
		send(ACT_FIND, 32'd0, 32'd0);
		send(ACT_INSERT, 32'd5, 32'h1);
		send(ACT_INSERT, 32'd5 + SLOTS, 32'h2);
		send(ACT_INSERT, 32'd5 + 2 * SLOTS, 32'h3);
		send(ACT_DELETE, 32'd5 + SLOTS, 32'd0);
		send(ACT_FIND, 32'd5 + 2 * SLOTS, 32'd0);
		send(ACT_INSERT, 32'd5 + 3 * SLOTS, 32'h4);
		send(ACT_FIND, 32'd5 + SLOTS, 32'd0);
		send(ACT_NONE, 32'h55AA55AA, 32'hAA55AA55);
		send(ACT_DELETE, 32'hFFFFFFFF, 32'd0);
		send(ACT_FIND, 32'hFFFFFFFF, 32'd0);
		drain();

		// short probe limits: zero, one, two, so collision chains run out
		set_limit(11'd0);
		send(ACT_INSERT, 32'd5 + 4 * SLOTS, 32'h5);
		send(ACT_FIND, 32'd5 + 2 * SLOTS, 32'd0);
		send(ACT_DELETE, 32'd5 + 3 * SLOTS, 32'd0);
		drain();
		set_limit(11'd1);
		send(ACT_FIND, 32'd5 + 2 * SLOTS, 32'd0);
		send(ACT_INSERT, 32'd5 + 5 * SLOTS, 32'h6);
		drain();
		set_limit(11'd2);
		random_run(60);
		drain();

		// no idling at the largest limit
		set_limit(11'd2047);
		random_run(150);
		drain();

		// sender idles
		set_limit(11'd1024);
		send_idle_pct = 69;
		random_run(150);
		drain();

		// receiver stalls, with one long hold-off while requests keep coming
		set_limit(11'd3);
		send_idle_pct = 0;
		recv_stall_pct = 69;
		hold_cycles = 300;
		random_run(150);
		drain();

		// both idle and stall
		set_limit(11'd1021);
		send_idle_pct = 19;
		recv_stall_pct = 19;
		random_run(150);
		drain();

		// bursts with no idling and no stalls
		set_limit(11'd8);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_run(170);
		drain();

		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#40000000;
		$display("status: fail");
		$finish;
	end

endmodule
